@@ hdl/constellation_map_demap_core_defines.svh @@
// ---------------------------------------------------------------------------
// Constellation map/demap assertion macros
// Property wrappers used by the core's top-level file to check its control flow.
// ---------------------------------------------------------------------------
`ifndef CONSTELLATION_MAP_DEMAP_CORE_DEFINES_SVH
`define CONSTELLATION_MAP_DEMAP_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CMDM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmdm assertion failed");

// next-cycle implication
`define CMDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmdm assertion failed");

`else

`define CMDM_ASSERT_NOW(label, clk, rst, ante, cons)
`define CMDM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/cmdm_pkg.sv @@
// ---------------------------------------------------------------------------
// Constellation map/demap package
// Widths, word types, request codes and controller/datapath interface.
// ---------------------------------------------------------------------------
package cmdm_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LG_W       = 4;
  localparam int LG_MIN     = 1;
  localparam int LG_MAX     = 8;
  localparam int COMP_W     = 16;
  localparam int DIFF_W     = COMP_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int DIST_W     = 35;
  localparam int ENTRY_W    = 2 * COMP_W;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_DEMAP = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        point_index;
    logic signed [COMP_W-1:0] in_real;
    logic signed [COMP_W-1:0] in_imag;
  } req_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_real;
    logic signed [COMP_W-1:0] out_imag;
    logic [IDX_W-1:0]        code_word;
    logic [DIST_W-1:0]       min_distance;
    logic                    range_error;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MAP_WAIT,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    RSP_HOLD,
    RSP_ZERO,
    RSP_RANGE,
    RSP_MAP,
    RSP_DEMAP
  } rsp_op_t;

  typedef struct packed {
    logic             capture;
    logic             write;
    logic             read_map;
    logic             scan_issue;
    logic [IDX_W-1:0] scan_addr;
    rsp_op_t          rsp_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             map_range_err;
    logic             pipe_busy;
    logic [IDX_W-1:0] last_index;
  } status_t;

endpackage

@@ hdl/cmdm_ctrl.sv @@
// ---------------------------------------------------------------------------
// Constellation map/demap controller
// Sequences load, map and demap words and steps the table scan.
// ---------------------------------------------------------------------------
module cmdm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cmdm_pkg::status_t status,
  output cmdm_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  cmdm_pkg::state_t state;
  cmdm_pkg::state_t state_next;
  logic [cmdm_pkg::IDX_W-1:0] scan_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmdm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (state == cmdm_pkg::S_DISPATCH) begin
      scan_cnt <= '0;
    end else if (state == cmdm_pkg::S_SCAN) begin
      scan_cnt <= scan_cnt + cmdm_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cmdm_pkg::S_IDLE: begin
        if (start) state_next = cmdm_pkg::S_DISPATCH;
      end
      cmdm_pkg::S_DISPATCH: begin
        case (status.req_type)
          cmdm_pkg::REQ_MAP: begin
            state_next = status.map_range_err ? cmdm_pkg::S_RESP : cmdm_pkg::S_MAP_WAIT;
          end
          cmdm_pkg::REQ_DEMAP: state_next = cmdm_pkg::S_SCAN;
          default:             state_next = cmdm_pkg::S_RESP;
        endcase
      end
      cmdm_pkg::S_MAP_WAIT: state_next = cmdm_pkg::S_RESP;
      cmdm_pkg::S_SCAN: begin
        if (scan_cnt == status.last_index) state_next = cmdm_pkg::S_DRAIN;
      end
      cmdm_pkg::S_DRAIN: begin
        if (!status.pipe_busy) state_next = cmdm_pkg::S_RESP;
      end
      cmdm_pkg::S_RESP: state_next = cmdm_pkg::S_IDLE;
      default:          state_next = cmdm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rsp_op     = cmdm_pkg::RSP_HOLD;
    cmd.scan_addr  = scan_cnt;
    busy           = (state != cmdm_pkg::S_IDLE);
    done           = (state == cmdm_pkg::S_RESP);
    case (state)
      cmdm_pkg::S_IDLE: cmd.capture = start;
      cmdm_pkg::S_DISPATCH: begin
        case (status.req_type)
          cmdm_pkg::REQ_LOAD: begin
            cmd.write  = 1'b1;
            cmd.rsp_op = cmdm_pkg::RSP_ZERO;
          end
          cmdm_pkg::REQ_MAP: begin
            if (status.map_range_err) begin
              cmd.rsp_op = cmdm_pkg::RSP_RANGE;
            end else begin
              cmd.read_map = 1'b1;
            end
          end
          cmdm_pkg::REQ_DEMAP: cmd.rsp_op = cmdm_pkg::RSP_HOLD;
          default:             cmd.rsp_op = cmdm_pkg::RSP_ZERO;
        endcase
      end
      cmdm_pkg::S_MAP_WAIT: cmd.rsp_op = cmdm_pkg::RSP_MAP;
      cmdm_pkg::S_SCAN:     cmd.scan_issue = 1'b1;
      cmdm_pkg::S_DRAIN: begin
        if (!status.pipe_busy) cmd.rsp_op = cmdm_pkg::RSP_DEMAP;
      end
      default: cmd.rsp_op = cmdm_pkg::RSP_HOLD;
    endcase
  end

endmodule

@@ hdl/cmdm_datapath.sv @@
// ---------------------------------------------------------------------------
// Constellation map/demap datapath
// Point table, size register, distance pipeline and result register.
// ---------------------------------------------------------------------------
module cmdm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cmdm_pkg::req_t                req,
  input  logic                          cfg_write,
  input  logic [cmdm_pkg::LG_W-1:0]     cfg_data,
  input  cmdm_pkg::cmd_t                cmd,
  output cmdm_pkg::status_t             status,
  output cmdm_pkg::rsp_t                rsp
);

  logic [cmdm_pkg::ENTRY_W-1:0] point_mem [cmdm_pkg::MAX_POINTS];

  cmdm_pkg::req_t                 req_q;
  logic [cmdm_pkg::LG_W-1:0]      size_log2;
  logic [cmdm_pkg::LG_W-1:0]      lg_clamped;
  logic [cmdm_pkg::CNT_W-1:0]     active_size;
  logic [cmdm_pkg::IDX_W-1:0]     rd_addr;
  logic [cmdm_pkg::ENTRY_W-1:0]   rdata;
  logic                           rd_valid;
  logic [cmdm_pkg::IDX_W-1:0]     rd_idx;
  logic signed [cmdm_pkg::DIFF_W-1:0] diff_re;
  logic signed [cmdm_pkg::DIFF_W-1:0] diff_im;
  logic signed [cmdm_pkg::PROD_W-1:0] prod_re;
  logic signed [cmdm_pkg::PROD_W-1:0] prod_im;
  logic                           sq_valid;
  logic [cmdm_pkg::IDX_W-1:0]     sq_idx;
  logic [cmdm_pkg::SQ_W-1:0]      sq_re;
  logic [cmdm_pkg::SQ_W-1:0]      sq_im;
  logic [cmdm_pkg::SUM_W-1:0]     sq_sum;
  logic [cmdm_pkg::SUM_W-1:0]     best;
  logic [cmdm_pkg::IDX_W-1:0]     best_idx;
  cmdm_pkg::rsp_t                 rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= cmdm_pkg::LG_W'(2);
    end else if (cfg_write) begin
      size_log2 <= cfg_data;
    end
  end

  always_comb begin
    if (size_log2 < cmdm_pkg::LG_W'(cmdm_pkg::LG_MIN)) begin
      lg_clamped = cmdm_pkg::LG_W'(cmdm_pkg::LG_MIN);
    end else if (size_log2 > cmdm_pkg::LG_W'(cmdm_pkg::LG_MAX)) begin
      lg_clamped = cmdm_pkg::LG_W'(cmdm_pkg::LG_MAX);
    end else begin
      lg_clamped = size_log2;
    end
  end

  assign active_size = (cmdm_pkg::CNT_W'(1) << lg_clamped) - cmdm_pkg::CNT_W'(1);

  assign status.req_type      = req_q.req_type;
  assign status.last_index    = active_size[cmdm_pkg::IDX_W-1:0];
  assign status.map_range_err = (req_q.point_index > status.last_index);
  assign status.pipe_busy     = rd_valid | sq_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  assign rd_addr = cmd.read_map ? req_q.point_index : cmd.scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      point_mem[req_q.point_index] <= {req_q.in_real, req_q.in_imag};
    end
    rdata <= point_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
      sq_valid <= rd_valid;
    end
  end

  assign diff_re = cmdm_pkg::DIFF_W'(req_q.in_real)
                 - cmdm_pkg::DIFF_W'($signed(rdata[cmdm_pkg::ENTRY_W-1:cmdm_pkg::COMP_W]));
  assign diff_im = cmdm_pkg::DIFF_W'(req_q.in_imag)
                 - cmdm_pkg::DIFF_W'($signed(rdata[cmdm_pkg::COMP_W-1:0]));
  assign prod_re = diff_re * diff_re;
  assign prod_im = diff_im * diff_im;

  always_ff @(posedge clk) begin
    rd_idx <= cmd.scan_addr;
    sq_idx <= rd_idx;
    sq_re  <= prod_re[cmdm_pkg::SQ_W-1:0];
    sq_im  <= prod_im[cmdm_pkg::SQ_W-1:0];
  end

  assign sq_sum = {1'b0, sq_re} + {1'b0, sq_im};

  always_ff @(posedge clk) begin
    if (sq_valid && ((sq_idx == '0) || (sq_sum < best))) begin
      best     <= sq_sum;
      best_idx <= sq_idx;
    end
  end

  always_comb begin
    rsp_next = rsp;
    case (cmd.rsp_op)
      cmdm_pkg::RSP_ZERO: rsp_next = '0;
      cmdm_pkg::RSP_RANGE: begin
        rsp_next             = '0;
        rsp_next.range_error = 1'b1;
      end
      cmdm_pkg::RSP_MAP: begin
        rsp_next          = '0;
        rsp_next.out_real = rdata[cmdm_pkg::ENTRY_W-1:cmdm_pkg::COMP_W];
        rsp_next.out_imag = rdata[cmdm_pkg::COMP_W-1:0];
      end
      cmdm_pkg::RSP_DEMAP: begin
        rsp_next              = '0;
        rsp_next.code_word    = best_idx;
        rsp_next.min_distance = cmdm_pkg::DIST_W'(best);
      end
      default: rsp_next = rsp;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

@@ hdl/constellation_map_demap_core.sv @@
// ---------------------------------------------------------------------------
// Constellation map/demap core
// Hard-decision mapper and minimum-distance demapper over a loaded table.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// rsp for exactly one cycle with done high, and cannot be held off. A load or
// an out-of-range map goes from dispatch to the response state; an in-range
// map adds a table read state. A demap scans n = 2^size_log2 entries, with
// size_log2 clamped to 1..8, through the single read port, one entry a cycle,
// then drains the pipeline; a new word is taken in the cycle after done.
module constellation_map_demap_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  cmdm_pkg::req_t                    req,
  output logic                              done,
  output cmdm_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmdm_pkg::LG_W-1:0]         cfg_data
);

  `include "constellation_map_demap_core_defines.svh"

  cmdm_pkg::cmd_t    cmd;
  cmdm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  cmdm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cmdm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

  `CMDM_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  `CMDM_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `CMDM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CMDM_ASSERT_NOW(a_scan_busy, clk, rst, cmd.scan_issue, busy && !done)
  `CMDM_ASSERT_NOW(a_err_clean, clk, rst, done && rsp.range_error, rsp.min_distance == '0)

endmodule
